// ===== rtl/pdc_pkg.sv =====
// Package for the two-axis filtered PD controller.
// Types, constants and register indexes shared by the lanes, interfaces and top level.
// No dependencies.
package pdc_pkg;

  localparam int COEF_FRAC_BITS_DEF = 12;

  localparam int VAL_W  = 8;
  localparam int COEF_W = 24;
  localparam int DRV_W  = 32;
  localparam int IDX_W  = 3;

  localparam logic CMD_VISION  = 1'b0;
  localparam logic CMD_ENCODER = 1'b1;

  localparam logic [IDX_W-1:0] REG_PAN_P_GAIN      = 3'd0;
  localparam logic [IDX_W-1:0] REG_PAN_D_FEEDBACK  = 3'd1;
  localparam logic [IDX_W-1:0] REG_PAN_D_GAIN      = 3'd2;
  localparam logic [IDX_W-1:0] REG_TILT_P_GAIN     = 3'd3;
  localparam logic [IDX_W-1:0] REG_TILT_D_FEEDBACK = 3'd4;
  localparam logic [IDX_W-1:0] REG_TILT_D_GAIN     = 3'd5;

  localparam logic signed [COEF_W-1:0] P_GAIN_RST      = 24'sd4096;
  localparam logic signed [COEF_W-1:0] D_FEEDBACK_RST  = 24'sd1755;
  localparam logic signed [COEF_W-1:0] D_GAIN_RST      = 24'sd0;

  typedef struct packed {
    logic signed [COEF_W-1:0] kp;
    logic signed [COEF_W-1:0] c1;
    logic signed [COEF_W-1:0] c2;
  } pdc_gain_t;

  // pipeline control shared by both lanes
  typedef struct packed {
    logic adv;      // whole pipeline moves this cycle
    logic acc_vis;  // vision word accepted
    logic acc_enc;  // encoder word accepted
    logic s2_v;     // products stage holds an encoder word
  } pdc_ctl_t;

endpackage

// ===== rtl/pdc_if.sv =====
// Handshake interfaces for the input and result channels.
// Depends on pdc_pkg.
interface pdc_in_if import pdc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    cmd;
  logic signed [VAL_W-1:0] pan_value;
  logic signed [VAL_W-1:0] tilt_value;

  modport source (output valid, cmd, pan_value, tilt_value, input ready);
  modport sink   (input valid, cmd, pan_value, tilt_value, output ready);
endinterface

interface pdc_out_if import pdc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [DRV_W-1:0] pan_drive;
  logic signed [DRV_W-1:0] tilt_drive;

  modport source (output valid, pan_drive, tilt_drive, input ready);
  modport sink   (input valid, pan_drive, tilt_drive, output ready);
endinterface

// ===== rtl/dual_axis_filtered_pd_controller.sv =====
// Top level of the two-axis filtered PD controller: config registers, pipeline
// control, two pdc_lane instances and the merging output register.
// Depends on pdc_pkg, pdc_if and pdc_lane.
//
//   channel  dir  fields                          handshake
//   in_bus   in   cmd, pan_value, tilt_value       valid/ready
//   out_bus  out  pan_drive, tilt_drive            valid/ready
//   cfg_*    in   cfg_index, cfg_data              cfg_we, no wait
//
// Encoder word: 4 register stages (error, products, D/P, merge). An encoder word holds
// in_bus.ready low until it leaves the error stage: the D feedback product must see
// the previous D. Vision words can follow back to back. Vision words yield no result.
// Reset is synchronous; it clears the gains, valid flags and lane loop state, not the
// data registers. A stalled output freezes the whole pipeline and drops in_bus.ready.
module dual_axis_filtered_pd_controller import pdc_pkg::*; #(
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  pdc_in_if.sink                   in_bus,
  pdc_out_if.source                out_bus,
  input  logic                     cfg_we,
  input  logic [IDX_W-1:0]         cfg_index,
  input  logic [COEF_W-1:0]        cfg_data
);

  pdc_gain_t pan_gain_r, tilt_gain_r;
  logic      s1_v_r, s2_v_r, s3_v_r, out_v_r;
  logic signed [DRV_W-1:0] pan_drive_r, tilt_drive_r;
  logic signed [DRV_W-1:0] pan_p, pan_d, tilt_p, tilt_d;
  logic signed [DRV_W-1:0] pan_drive_nxt, tilt_drive_nxt;
  logic signed [DRV_W:0]   pan_sum, tilt_sum;
  logic      adv, acc;
  pdc_ctl_t  ctl;

  assign adv = !out_v_r || out_bus.ready;
  assign in_bus.ready = adv && !s1_v_r;
  assign acc = in_bus.valid && in_bus.ready;

  assign ctl.adv     = adv;
  assign ctl.acc_vis = acc && (in_bus.cmd == CMD_VISION);
  assign ctl.acc_enc = acc && (in_bus.cmd == CMD_ENCODER);
  assign ctl.s2_v    = s2_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pan_gain_r  <= '{kp: P_GAIN_RST, c1: D_FEEDBACK_RST, c2: D_GAIN_RST};
      tilt_gain_r <= '{kp: P_GAIN_RST, c1: D_FEEDBACK_RST, c2: D_GAIN_RST};
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PAN_P_GAIN:      pan_gain_r.kp  <= cfg_data;
        REG_PAN_D_FEEDBACK:  pan_gain_r.c1  <= cfg_data;
        REG_PAN_D_GAIN:      pan_gain_r.c2  <= cfg_data;
        REG_TILT_P_GAIN:     tilt_gain_r.kp <= cfg_data;
        REG_TILT_D_FEEDBACK: tilt_gain_r.c1 <= cfg_data;
        REG_TILT_D_GAIN:     tilt_gain_r.c2 <= cfg_data;
        default: ;
      endcase
    end
  end

  pdc_lane #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_pan (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .gain   (pan_gain_r),
    .value  (in_bus.pan_value),
    .p_term (pan_p),
    .d_term (pan_d)
  );

  pdc_lane #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_tilt (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .gain   (tilt_gain_r),
    .value  (in_bus.tilt_value),
    .p_term (tilt_p),
    .d_term (tilt_d)
  );

  // merge: P + D with saturation
  always_comb begin
    pan_sum  = (DRV_W+1)'(pan_p) + (DRV_W+1)'(pan_d);
    tilt_sum = (DRV_W+1)'(tilt_p) + (DRV_W+1)'(tilt_d);
    if (pan_sum[DRV_W] == pan_sum[DRV_W-1]) begin
      pan_drive_nxt = pan_sum[DRV_W-1:0];
    end else begin
      pan_drive_nxt = {pan_sum[DRV_W], {(DRV_W-1){!pan_sum[DRV_W]}}};
    end
    if (tilt_sum[DRV_W] == tilt_sum[DRV_W-1]) begin
      tilt_drive_nxt = tilt_sum[DRV_W-1:0];
    end else begin
      tilt_drive_nxt = {tilt_sum[DRV_W], {(DRV_W-1){!tilt_sum[DRV_W]}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r  <= ctl.acc_enc;
      s2_v_r  <= s1_v_r;
      s3_v_r  <= s2_v_r;
      out_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s3_v_r) begin
      pan_drive_r  <= pan_drive_nxt;
      tilt_drive_r <= tilt_drive_nxt;
    end
  end

  assign out_bus.valid      = out_v_r;
  assign out_bus.pan_drive  = pan_drive_r;
  assign out_bus.tilt_drive = tilt_drive_r;

endmodule

// ===== rtl/pdc_lane.sv =====
// One controller axis: target/measurement state, error, products and filtered D term.
// Depends on pdc_pkg; instantiated once per axis by the top level.
module pdc_lane import pdc_pkg::*; #(
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  pdc_ctl_t                ctl,
  input  pdc_gain_t               gain,
  input  logic signed [VAL_W-1:0] value,
  output logic signed [DRV_W-1:0] p_term,
  output logic signed [DRV_W-1:0] d_term
);

  localparam int PROD_P_W = COEF_W + VAL_W;
  localparam int PROD_F_W = COEF_W + DRV_W;
  localparam int PROD_E_W = COEF_W + VAL_W + 1;
  localparam int ACC_W    = PROD_F_W + 2;

  logic signed [VAL_W-1:0]    measured_r, target_r, last_err_r;
  logic signed [VAL_W-1:0]    e_r;
  logic signed [VAL_W:0]      de_r;
  logic signed [PROD_P_W-1:0] kpe_r;
  logic signed [PROD_F_W-1:0] c1d_r;
  logic signed [PROD_E_W-1:0] c2de_r;
  logic signed [DRV_W-1:0]    dprev_r, p_r, d_r;

  logic signed [VAL_W-1:0]    e_nxt;
  logic signed [ACC_W-1:0]    acc, acc_bias, acc_q;
  logic signed [PROD_P_W-1:0] p_bias, p_q;
  logic signed [DRV_W-1:0]    d_nxt;

  assign e_nxt = target_r - value;

  always_comb begin
    acc      = ACC_W'(c2de_r) - ACC_W'(c1d_r);
    acc_bias = acc[ACC_W-1] ? ((ACC_W'(1) <<< COEF_FRAC_BITS) - ACC_W'(1)) : '0;
    acc_q    = (acc + acc_bias) >>> COEF_FRAC_BITS;
    if (acc_q[ACC_W-1:DRV_W-1] == '0 || acc_q[ACC_W-1:DRV_W-1] == '1) begin
      d_nxt = acc_q[DRV_W-1:0];
    end else if (acc_q[ACC_W-1]) begin
      d_nxt = {1'b1, {(DRV_W-1){1'b0}}};
    end else begin
      d_nxt = {1'b0, {(DRV_W-1){1'b1}}};
    end
    p_bias = kpe_r[PROD_P_W-1] ? ((PROD_P_W'(1) <<< COEF_FRAC_BITS) - PROD_P_W'(1)) : '0;
    p_q    = (kpe_r + p_bias) >>> COEF_FRAC_BITS;
  end

  // front state, updated as words are accepted; the previous D updates as a word leaves the products stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      measured_r <= '0;
      target_r   <= '0;
      last_err_r <= '0;
      dprev_r    <= '0;
    end else begin
      if (ctl.acc_vis) begin
        target_r <= value + measured_r;
      end
      if (ctl.acc_enc) begin
        measured_r <= value;
        last_err_r <= e_nxt;
      end
      if (ctl.adv && ctl.s2_v) begin
        dprev_r <= d_nxt;
      end
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (ctl.acc_enc) begin
      e_r  <= e_nxt;
      de_r <= (VAL_W+1)'(e_nxt) - (VAL_W+1)'(last_err_r);
    end
    if (ctl.adv) begin
      kpe_r  <= PROD_P_W'(gain.kp * e_r);
      c1d_r  <= PROD_F_W'(gain.c1 * dprev_r);
      c2de_r <= PROD_E_W'(gain.c2 * de_r);
      p_r    <= p_q[DRV_W-1:0];
      d_r    <= d_nxt;
    end
  end

  assign p_term = p_r;
  assign d_term = d_r;

endmodule

// ===== tb/dual_axis_filtered_pd_controller_tb.sv =====
// Testbench for the two-axis filtered PD controller: a drive predictor with its own copy of
// gains and loop state checks every result word against the word stream it was fed.
// Depends on pdc_pkg, pdc_if and the dual_axis_filtered_pd_controller top level.
module dual_axis_filtered_pd_controller_tb;
  import pdc_pkg::*;

  localparam int RUN_LIMIT   = 400000;
  localparam int PHASES      = 8;
  localparam int PHASE_WORDS = 220;
  localparam int SETTLE      = 10;
  localparam int HOLD_LEN    = 600;
  localparam int REPORT_MAX  = 10;

  localparam longint COEF_SCALE = longint'(1) << COEF_FRAC_BITS_DEF;
  localparam longint DRV_MAX    = (longint'(1) << (DRV_W - 1)) - 1;
  localparam longint DRV_MIN    = -(longint'(1) << (DRV_W - 1));

  localparam logic [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};
  localparam logic [VAL_W-1:0]  VAL_MAX  = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0]  VAL_MIN  = {1'b1, {(VAL_W-1){1'b0}}};

  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct {
    logic signed [DRV_W-1:0] pan;
    logic signed [DRV_W-1:0] tilt;
  } drive_pair_t;

  class pd_drive_predictor;
    pdc_gain_t               pan_gain;
    pdc_gain_t               tilt_gain;
    logic signed [VAL_W-1:0] pan_meas, tilt_meas;
    logic signed [VAL_W-1:0] pan_target, tilt_target;
    logic signed [VAL_W-1:0] pan_err, tilt_err;
    logic signed [DRV_W-1:0] pan_deriv, tilt_deriv;
    drive_pair_t             expected_drives[$];
    int                      mismatches;

    function new();
      pan_gain    = '{kp: P_GAIN_RST, c1: D_FEEDBACK_RST, c2: D_GAIN_RST};
      tilt_gain   = pan_gain;
      pan_meas    = '0;
      tilt_meas   = '0;
      pan_target  = '0;
      tilt_target = '0;
      pan_err     = '0;
      tilt_err    = '0;
      pan_deriv   = '0;
      tilt_deriv  = '0;
      mismatches  = 0;
    endfunction

    function void set_reg(input logic [IDX_W-1:0] idx, input logic [COEF_W-1:0] data);
      case (idx)
        REG_PAN_P_GAIN:      pan_gain.kp  = data;
        REG_PAN_D_FEEDBACK:  pan_gain.c1  = data;
        REG_PAN_D_GAIN:      pan_gain.c2  = data;
        REG_TILT_P_GAIN:     tilt_gain.kp = data;
        REG_TILT_D_FEEDBACK: tilt_gain.c1 = data;
        REG_TILT_D_GAIN:     tilt_gain.c2 = data;
        default: ;
      endcase
    endfunction

    function longint clamp32(input longint v);
      if (v > DRV_MAX) return DRV_MAX;
      if (v < DRV_MIN) return DRV_MIN;
      return v;
    endfunction

    function logic signed [DRV_W-1:0] axis_drive(input pdc_gain_t g,
                                                 input logic signed [VAL_W-1:0] target,
                                                 input logic signed [VAL_W-1:0] meas,
                                                 inout logic signed [VAL_W-1:0] last_err,
                                                 inout logic signed [DRV_W-1:0] last_d);
      logic signed [VAL_W-1:0] e;
      longint de, p, acc, d;
      e   = target - meas;
      de  = longint'(e) - longint'(last_err);
      p   = longint'(g.kp) * longint'(e) / COEF_SCALE;
      acc = longint'(g.c2) * de - longint'(g.c1) * longint'(last_d);
      d   = clamp32(acc / COEF_SCALE);
      last_err = e;
      last_d   = d[DRV_W-1:0];
      return DRV_W'(clamp32(p + d));
    endfunction

    function void note_word(input logic cmd, input logic signed [VAL_W-1:0] pv,
                            input logic signed [VAL_W-1:0] tv);
      drive_pair_t r;
      if (cmd == CMD_VISION) begin
        pan_target  = pv + pan_meas;
        tilt_target = tv + tilt_meas;
      end else begin
        pan_meas  = pv;
        tilt_meas = tv;
        r.pan  = axis_drive(pan_gain, pan_target, pan_meas, pan_err, pan_deriv);
        r.tilt = axis_drive(tilt_gain, tilt_target, tilt_meas, tilt_err, tilt_deriv);
        expected_drives.push_back(r);
      end
    endfunction

    function void check_drive(input logic signed [DRV_W-1:0] pan,
                              input logic signed [DRV_W-1:0] tilt);
      drive_pair_t r;
      if (expected_drives.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("drive word pan %0d tilt %0d with nothing expected", pan, tilt);
        return;
      end
      r = expected_drives.pop_front();
      if (r.pan !== pan || r.tilt !== tilt) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("drive mismatch: pan exp %0d got %0d, tilt exp %0d got %0d",
                   r.pan, pan, r.tilt, tilt);
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_we;
  logic [IDX_W-1:0]  cfg_index;
  logic [COEF_W-1:0] cfg_data;

  pdc_in_if  in_bus();
  pdc_out_if out_bus();

  dual_axis_filtered_pd_controller dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .out_bus   (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pd_drive_predictor drives;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_request;
  int hold_left   = 0;
  bit hold_done   = 1'b0;
  int cycle_count = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > RUN_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // result side: check accepted words, then pick ready for the next cycle
  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready)
      drives.check_drive(out_bus.pan_drive, out_bus.tilt_drive);
    if (hold_left > 0) begin
      hold_left--;
      out_bus.ready <= 1'b0;
    end else if (hold_request > 0 && !hold_done) begin
      hold_left = hold_request;
      hold_done = 1'b1;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic set_idling(input idle_mode_t mode);
    case (mode)
      IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SENDER:   begin send_idle_pct = 65; recv_stall_pct = 0;  end
      IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 65; end
      default:       begin send_idle_pct = 11; recv_stall_pct = 11; end
    endcase
  endtask

  // leaves valid high so back-to-back words need no extra edge
  task automatic send_word(input logic cmd, input logic signed [VAL_W-1:0] pv,
                           input logic signed [VAL_W-1:0] tv);
    if ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_bus.valid      <= 1'b1;
    in_bus.cmd        <= cmd;
    in_bus.pan_value  <= pv;
    in_bus.tilt_value <= tv;
    do @(posedge clk); while (!in_bus.ready);
    drives.note_word(cmd, pv, tv);
  endtask

  task automatic wait_idle();
    in_bus.valid <= 1'b0;
    while (drives.expected_drives.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [IDX_W-1:0] idx, input logic [COEF_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    drives.set_reg(idx, data);
  endtask

  // all six gains plus the unused indexes, which must be ignored
  task automatic load_gains(input pdc_gain_t pan_g, input pdc_gain_t tilt_g);
    write_cfg(REG_PAN_P_GAIN, pan_g.kp);
    write_cfg(REG_PAN_D_FEEDBACK, pan_g.c1);
    write_cfg(REG_PAN_D_GAIN, pan_g.c2);
    write_cfg(REG_TILT_P_GAIN, tilt_g.kp);
    write_cfg(REG_TILT_D_FEEDBACK, tilt_g.c1);
    write_cfg(REG_TILT_D_GAIN, tilt_g.c2);
    for (int i = REG_TILT_D_GAIN + 1; i < 2**IDX_W; i++)
      write_cfg(i[IDX_W-1:0], COEF_W'($urandom));
    cfg_we <= 1'b0;
  endtask

  function automatic logic [COEF_W-1:0] pick_coef();
    case ($urandom_range(6))
      0:       return COEF_W'($urandom);
      1:       return COEF_MAX;
      2:       return COEF_MIN;
      3, 4:    return COEF_W'($urandom_range(16384) - 8192);
      5:       return D_FEEDBACK_RST;
      default: return '0;
    endcase
  endfunction

  function automatic pdc_gain_t pick_gain();
    pdc_gain_t g;
    g.kp = pick_coef();
    g.c1 = pick_coef();
    g.c2 = pick_coef();
    return g;
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(9))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      default: return VAL_W'($urandom);
    endcase
  endfunction

  initial begin
    drives = new();
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_data          = '0;
    in_bus.valid      = 1'b0;
    in_bus.cmd        = CMD_VISION;
    in_bus.pan_value  = '0;
    in_bus.tilt_value = '0;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    hold_request      = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset gains: plain errors, target wrap, error wrap
    send_word(CMD_ENCODER, '0, '0);
    send_word(CMD_VISION, VAL_MAX, VAL_MIN);
    send_word(CMD_ENCODER, '0, '0);
    send_word(CMD_VISION, VAL_MAX, VAL_MAX);
    send_word(CMD_ENCODER, VAL_MIN, VAL_MIN);
    send_word(CMD_VISION, VAL_MIN, VAL_MIN);
    send_word(CMD_ENCODER, VAL_MAX, VAL_MAX);
    wait_idle();

    // extreme gains: full-swing error steps, derivative and drive saturation
    load_gains('{kp: COEF_MAX, c1: COEF_MIN, c2: COEF_MAX},
               '{kp: COEF_MIN, c1: COEF_MAX, c2: COEF_MIN});
    send_word(CMD_VISION, VAL_MAX, VAL_MIN);
    send_word(CMD_ENCODER, VAL_MIN, VAL_MAX);
    send_word(CMD_ENCODER, VAL_MAX, VAL_MIN);
    send_word(CMD_VISION, '0, '0);
    send_word(CMD_ENCODER, VAL_MAX, VAL_MIN);
    send_word(CMD_ENCODER, VAL_MIN, VAL_MAX);
    send_word(CMD_ENCODER, VAL_MAX, VAL_MIN);
    send_word(CMD_ENCODER, VAL_MIN, VAL_MAX);
    send_word(CMD_ENCODER, VAL_MAX, VAL_MIN);
    wait_idle();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       load_gains('{kp: COEF_MAX, c1: COEF_MAX, c2: COEF_MAX},
                            '{kp: COEF_MAX, c1: COEF_MAX, c2: COEF_MAX});
        1:       load_gains('{kp: COEF_MIN, c1: COEF_MIN, c2: COEF_MIN},
                            '{kp: COEF_MIN, c1: COEF_MIN, c2: COEF_MIN});
        default: load_gains(pick_gain(), pick_gain());
      endcase
      set_idling(idle_mode_t'(ph % 4));
      if (ph == 4) hold_request = HOLD_LEN;
      for (int n = 0; n < PHASE_WORDS; n++)
        send_word(($urandom_range(9) < 6) ? CMD_ENCODER : CMD_VISION,
                  pick_value(), pick_value());
      wait_idle();
    end

    if (drives.mismatches == 0 && drives.expected_drives.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== dual_axis_filtered_pd_controller.f =====
rtl/pdc_pkg.sv
rtl/pdc_if.sv
rtl/pdc_lane.sv
rtl/dual_axis_filtered_pd_controller.sv
tb/dual_axis_filtered_pd_controller_tb.sv
